// File: rtl/dfq_pkg.sv
// dfq_pkg: shared constants, codes and types of the duplicate-rejecting queue.
// No dependencies; used by the interfaces, the cell row and the top level.
`timescale 1ns / 1ps

package dfq_pkg;

  // Queue geometry
  localparam int DEPTH = 16;
  localparam int KEY_W = 32;
  localparam int CNT_W = $clog2(DEPTH + 1);

  // Request kinds
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_DUP   = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  // Per-cycle command broadcast to every cell
  typedef struct packed {
    logic enq;   // append the broadcast key at the first free cell
    logic deq;   // every cell takes its upstream neighbor's contents
  } cell_cmd_t;

  // Summary of the row returned to the controller
  typedef struct packed {
    logic dup;    // broadcast key already held
    logic full;   // last cell occupied
    logic empty;  // head cell free
  } row_stat_t;

endpackage

// File: rtl/dfq_if.sv
// dfq_in_if / dfq_out_if: valid-ready request and result channels.
// Depends on dfq_pkg for the key and count types.
`timescale 1ns / 1ps

interface dfq_in_if;
  logic          valid;
  logic          ready;
  logic          action;
  dfq_pkg::key_t key_in;

  modport source(output valid, output action, output key_in, input ready);
  modport sink(input valid, input action, input key_in, output ready);
endinterface

interface dfq_out_if;
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  dfq_pkg::key_t key_out;
  dfq_pkg::cnt_t occupancy;

  modport source(output valid, output status, output key_out, output occupancy, input ready);
  modport sink(input valid, input status, input key_out, input occupancy, output ready);
endinterface

// File: rtl/dfq_cell.sv
// dfq_cell: one slot of the shifting queue: a key, an occupied flag and a
// key comparator. Depends on dfq_pkg.
`timescale 1ns / 1ps

module dfq_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  dfq_pkg::cell_cmd_t cmd,
  input  dfq_pkg::key_t     bcast_key,
  input  logic              prev_valid,  // downstream (toward head) neighbor occupied
  input  dfq_pkg::key_t     up_key,      // upstream (toward tail) neighbor contents
  input  logic              up_valid,
  output dfq_pkg::key_t     key,
  output logic              valid,
  output logic              hit
);

  dfq_pkg::key_t key_r, key_nxt;
  logic          valid_r, valid_nxt;
  logic          load;

  // First free cell takes the appended key
  assign load = cmd.enq & ~valid_r & prev_valid;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (cmd.deq) begin
      key_nxt   = up_key;
      valid_nxt = up_valid;
    end else if (load) begin
      key_nxt   = bcast_key;
      valid_nxt = 1'b1;
    end
  end

  // Occupied flag is control state; the key is payload
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  assign key   = key_r;
  assign valid = valid_r;
  assign hit   = valid_r & (key_r == bcast_key);

endmodule

// File: rtl/dfq_row.sv
// dfq_row: the row of DEPTH cells, head at cell 0; keys move toward the head
// on a dequeue. Depends on dfq_pkg and dfq_cell.
`timescale 1ns / 1ps

module dfq_row (
  input  logic               clk,
  input  logic               rst_n,
  input  dfq_pkg::cell_cmd_t cmd,
  input  dfq_pkg::key_t      bcast_key,
  output dfq_pkg::key_t      head_key,
  output dfq_pkg::row_stat_t stat
);

  dfq_pkg::key_t               key_a   [dfq_pkg::DEPTH];
  logic [dfq_pkg::DEPTH-1:0]   valid_v;
  logic [dfq_pkg::DEPTH-1:0]   hit_v;

  genvar i;
  generate
    for (i = 0; i < dfq_pkg::DEPTH; i++) begin : g_cell
      logic          prev_valid;
      dfq_pkg::key_t up_key;
      logic          up_valid;

      // Neighbor wiring; the head sees an occupied neighbor, the tail an empty one
      if (i == 0) begin : g_head
        assign prev_valid = 1'b1;
      end else begin : g_body
        assign prev_valid = valid_v[i-1];
      end

      if (i == dfq_pkg::DEPTH - 1) begin : g_tail
        assign up_key   = key_a[i];
        assign up_valid = 1'b0;
      end else begin : g_mid
        assign up_key   = key_a[i+1];
        assign up_valid = valid_v[i+1];
      end

      dfq_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .bcast_key  (bcast_key),
        .prev_valid (prev_valid),
        .up_key     (up_key),
        .up_valid   (up_valid),
        .key        (key_a[i]),
        .valid      (valid_v[i]),
        .hit        (hit_v[i])
      );
    end
  endgenerate

  assign head_key   = key_a[0];
  assign stat.dup   = |hit_v;
  assign stat.full  = valid_v[dfq_pkg::DEPTH-1];
  assign stat.empty = ~valid_v[0];

endmodule

// File: rtl/dedup_fifo_queue.sv
// dedup_fifo_queue: top level of the duplicate-rejecting key queue.
// Depends on dfq_pkg, dfq_if and dfq_row.
//
//   channel | port    | direction | carries
//   --------+---------+-----------+-------------------------------
//   request | in_ch   | sink      | action, key_in
//   result  | out_ch  | source    | status, key_out, occupancy
//
// One request is taken per cycle; its result sits in the output register the
// cycle after acceptance. All DEPTH cells compare the key in parallel. Reset
// empties the queue. While a result is held and the sink stalls, in_ch.ready
// stays low.
`timescale 1ns / 1ps

module dedup_fifo_queue (
  input  logic      clk,
  input  logic      rst_n,
  dfq_in_if.sink    in_ch,
  dfq_out_if.source out_ch
);

  dfq_pkg::cell_cmd_t cmd;
  dfq_pkg::row_stat_t stat;
  dfq_pkg::key_t      head_key;

  logic               accept;
  logic               enq_ok, deq_ok;
  logic [1:0]         status_nxt;
  dfq_pkg::key_t      key_out_nxt;
  dfq_pkg::cnt_t      count_r, count_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         status_r;
  dfq_pkg::key_t      key_out_r;
  dfq_pkg::cnt_t      occ_r;

  // Handshake: accept when the result register is free or draining
  assign in_ch.ready = ~out_valid_r | out_ch.ready;
  assign accept      = in_ch.valid & in_ch.ready;

  // Decode the request against the row summary
  always_comb begin
    enq_ok      = 1'b0;
    deq_ok      = 1'b0;
    status_nxt  = dfq_pkg::ST_OK;
    key_out_nxt = '0;
    unique case (in_ch.action)
      dfq_pkg::ACT_ENQ: begin
        if (stat.dup) begin
          status_nxt = dfq_pkg::ST_DUP;
        end else if (stat.full) begin
          status_nxt = dfq_pkg::ST_FULL;
        end else begin
          enq_ok = accept;
        end
      end
      dfq_pkg::ACT_DEQ: begin
        if (stat.empty) begin
          status_nxt = dfq_pkg::ST_EMPTY;
        end else begin
          deq_ok      = accept;
          key_out_nxt = head_key;
        end
      end
      default: begin
        status_nxt = dfq_pkg::ST_OK;
      end
    endcase
  end

  assign cmd.enq = enq_ok;
  assign cmd.deq = deq_ok;

  dfq_row u_row (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .bcast_key (in_ch.key_in),
    .head_key  (head_key),
    .stat      (stat)
  );

  // Occupancy counter
  always_comb begin
    count_nxt = count_r;
    if (enq_ok) begin
      count_nxt = count_r + dfq_pkg::CNT_W'(1);
    end else if (deq_ok) begin
      count_nxt = count_r - dfq_pkg::CNT_W'(1);
    end
  end

  assign out_valid_nxt = accept | (out_valid_r & ~out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r  <= status_nxt;
      key_out_r <= key_out_nxt;
      occ_r     <= count_nxt;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.status    = status_r;
  assign out_ch.key_out   = key_out_r;
  assign out_ch.occupancy = occ_r;

endmodule

// File: sim/dedup_fifo_queue_tb.sv
// dedup_fifo_queue_tb: self-checking bench for the duplicate-rejecting key queue.
// Depends on dfq_pkg, dfq_if (request/result channels) and dedup_fifo_queue.
// Directed then random requests are scored against a behavioral copy of the queue.
`timescale 1ns / 1ps

module dedup_fifo_queue_tb;

  localparam int            CLK_HALF     = 10;
  localparam int            RST_CYCLES   = 12;
  localparam int            CHUNKS       = 7;
  localparam int            CHUNK_REQS   = 75;
  localparam int            REFILL_MARK  = 10;
  localparam int            POOL_SIZE    = 20;
  localparam int            LONG_HOLD    = 80;
  localparam int            DRAIN_CYCLES = 20;
  localparam int unsigned   CYCLE_LIMIT  = 200000;
  localparam dfq_pkg::key_t KEY_MIN      = dfq_pkg::key_t'(32'h8000_0000);
  localparam dfq_pkg::key_t KEY_MAX      = dfq_pkg::key_t'(32'h7FFF_FFFF);

  typedef struct {
    logic          action;
    dfq_pkg::key_t key;
  } queue_req_t;

  typedef struct {
    logic [1:0]    status;
    dfq_pkg::key_t key;
    dfq_pkg::cnt_t occupancy;
  } queue_res_t;

  bit   clk;
  logic rst_n = 1'b0;

  dfq_in_if  req_if ();
  dfq_out_if res_if ();

  dedup_fifo_queue DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (req_if),
    .out_ch (res_if)
  );

  queue_req_t req_backlog[$];    // requests not yet accepted
  queue_res_t expected_res[$];   // results owed by the block, oldest first

  // Behavioral queue: circular key store, head slot and key count
  dfq_pkg::key_t held_keys[dfq_pkg::DEPTH];
  int            held_head;
  int            held_count;

  bit idle_on;
  bit long_hold_req;
  bit offer_live;
  int gap_left;
  int stall_left;
  int fail_count;

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Applies one request to the behavioral queue and returns its result
  function automatic queue_res_t apply_queue_req(queue_req_t req);
    queue_res_t res;
    bit         held;
    res.status = dfq_pkg::ST_OK;
    res.key    = '0;
    held       = 1'b0;
    if (req.action == dfq_pkg::ACT_ENQ) begin
      for (int i = 0; i < held_count; i++)
        if (held_keys[(held_head + i) % dfq_pkg::DEPTH] == req.key) held = 1'b1;
      // duplicate wins over full
      if (held) begin
        res.status = dfq_pkg::ST_DUP;
      end else if (held_count >= dfq_pkg::DEPTH) begin
        res.status = dfq_pkg::ST_FULL;
      end else begin
        held_keys[(held_head + held_count) % dfq_pkg::DEPTH] = req.key;
        held_count++;
      end
    end else if (held_count == 0) begin
      res.status = dfq_pkg::ST_EMPTY;
    end else begin
      res.key   = held_keys[held_head];
      held_head = (held_head + 1) % dfq_pkg::DEPTH;
      held_count--;
    end
    res.occupancy = dfq_pkg::cnt_t'(held_count);
    return res;
  endfunction

  task automatic push_req(input logic act, input dfq_pkg::key_t key);
    queue_req_t r;
    r.action = act;
    r.key    = key;
    req_backlog.push_back(r);
  endtask

  // Driver: offers the backlog front, holds it until accepted, random gaps
  always @(negedge clk) begin
    if (rst_n && !offer_live) begin
      if (gap_left != 0) begin
        req_if.valid <= 1'b0;
        gap_left--;
      end else if (req_backlog.size() == 0) begin
        req_if.valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        req_if.valid <= 1'b0;
        gap_left = $urandom_range(0, 6);
      end else begin
        req_if.valid  <= 1'b1;
        req_if.action <= req_backlog[0].action;
        req_if.key_in <= req_backlog[0].key;
        offer_live = 1'b1;
      end
    end
  end

  // Result sink: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (rst_n) begin
      if (long_hold_req) begin
        stall_left    = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (stall_left != 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 6);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  // Monitor: scores results first, then records the request taken this edge
  always @(posedge clk) begin
    queue_res_t want;
    queue_req_t req;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (expected_res.size() == 0) begin
        $error("unexpected result: status %0d key_out %0d occupancy %0d",
               res_if.status, res_if.key_out, res_if.occupancy);
        fail_count++;
      end else begin
        want = expected_res.pop_front();
        if (res_if.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, res_if.status);
          fail_count++;
        end
        if (res_if.key_out !== want.key) begin
          $error("key_out: expected %0d, got %0d", want.key, res_if.key_out);
          fail_count++;
        end
        if (res_if.occupancy !== want.occupancy) begin
          $error("occupancy: expected %0d, got %0d", want.occupancy, res_if.occupancy);
          fail_count++;
        end
      end
    end
    if (rst_n && req_if.valid && req_if.ready) begin
      req.action = req_if.action;
      req.key    = req_if.key_in;
      expected_res.push_back(apply_queue_req(req));
      void'(req_backlog.pop_front());
      offer_live = 1'b0;
    end
  end

  // Stimulus and end of run
  initial begin
    dfq_pkg::key_t key_pool[POOL_SIZE];
    queue_req_t    r;
    int            enq_pct;
    req_if.valid  = 1'b0;
    req_if.action = dfq_pkg::ACT_ENQ;
    req_if.key_in = '0;
    res_if.ready  = 1'b0;
    idle_on       = 1'b1;
    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty dequeue, key extremes, duplicate, refill after removal
    push_req(dfq_pkg::ACT_DEQ, '0);
    push_req(dfq_pkg::ACT_ENQ, KEY_MIN);
    push_req(dfq_pkg::ACT_ENQ, KEY_MAX);
    push_req(dfq_pkg::ACT_ENQ, '0);
    push_req(dfq_pkg::ACT_ENQ, -1);
    push_req(dfq_pkg::ACT_ENQ, KEY_MIN);            // already held
    push_req(dfq_pkg::ACT_DEQ, KEY_MAX);            // key_in ignored
    push_req(dfq_pkg::ACT_ENQ, KEY_MIN);            // removed, so accepted again
    for (int i = 0; i < dfq_pkg::DEPTH - 4; i++)
      push_req(dfq_pkg::ACT_ENQ, dfq_pkg::key_t'(32'h5A5A_0000 + i));
    push_req(dfq_pkg::ACT_ENQ, dfq_pkg::key_t'(32'h1234_5678));   // queue full
    push_req(dfq_pkg::ACT_ENQ, '0);                      // held and full: duplicate
    push_req(dfq_pkg::ACT_DEQ, -1);
    push_req(dfq_pkg::ACT_ENQ, dfq_pkg::key_t'(32'hA5A5_A5A5));   // tail wraps
    push_req(dfq_pkg::ACT_DEQ, '0);

    // sender quiet until every result is back
    while (req_backlog.size() != 0 || offer_live || expected_res.size() != 0)
      @(posedge clk);

    // Random: small key pool mixed with fresh keys, enqueue bias alternating
    for (int p = 0; p < POOL_SIZE; p++) key_pool[p] = dfq_pkg::key_t'($urandom());
    for (int c = 0; c < CHUNKS; c++) begin
      if (c == CHUNKS - 1) begin
        while (req_backlog.size() != 0) @(posedge clk);
        idle_on = 1'b0;
      end else begin
        while (req_backlog.size() > REFILL_MARK) @(posedge clk);
        idle_on = (c != 3);
      end
      enq_pct = (c % 2 == 0) ? 75 : 35;
      for (int n = 0; n < CHUNK_REQS; n++) begin
        r.action = ($urandom_range(1, 100) <= enq_pct) ? dfq_pkg::ACT_ENQ
                                                       : dfq_pkg::ACT_DEQ;
        r.key    = $urandom_range(0, 1) ? key_pool[$urandom_range(0, POOL_SIZE - 1)]
                                        : dfq_pkg::key_t'($urandom());
        req_backlog.push_back(r);
      end
      // sink holds off while the sender keeps offering
      if (c == 2) long_hold_req = 1'b1;
    end

    while (req_backlog.size() != 0 || offer_live || expected_res.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    int unsigned run_cycles;
    run_cycles = 0;
    while (run_cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      run_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
